/* hw/rtl/tkm_pkg.sv */
// shared types, constants and helpers for the top-k magnitude tracker
// used by tkm_cell, tkm_chain and top_k_by_magnitude_tracker
`timescale 1ns / 1ps
`default_nettype none

package tkm_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int RATE_W = 32;
    localparam int TAG_W  = 32;
    localparam int YEAR_W = 12;
    localparam int RANK_W = 7;
    localparam int MAG_W  = 31;
    localparam int KEEP_W = 8;
    localparam int CNTO_W = 8;

    localparam int CMP_W = (IDX_W > RANK_W) ? IDX_W : RANK_W;
    localparam int LIM_W = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

    localparam logic [KEEP_W-1:0] KEEP_RESET = 8'd100;

    // stream payload widths
    localparam int S_DATA_W = 88;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 152;

    // apb
    localparam int ADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_KEEP_COUNT = 1'b0;

    typedef enum logic {
        OP_OFFER = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_GATHER
    } state_t;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [TAG_W-1:0]  tag;
        logic [YEAR_W-1:0] year;
    } slot_t;

    // broadcast from the control to every cell
    typedef struct packed {
        logic              upd;
        logic [MAG_W-1:0]  mag;
        slot_t             slot;
        logic [RANK_W-1:0] rank;
        logic [CNT_W-1:0]  held;
    } cmd_t;

    // reduced status from the chain back to the control
    typedef struct packed {
        logic             bot_gt;
        logic             hit;
        slot_t            pick;
        logic [MAG_W-1:0] bot_mag;
        logic [MAG_W-1:0] top_mag;
    } chain_stat_t;

    // |rate| as unsigned q0.31, -1.0 saturates to the largest value
    function automatic logic [MAG_W-1:0] magnitude(input logic [RATE_W-1:0] r);
        logic [RATE_W-1:0] neg;
        begin
            neg = ~r + RATE_W'(1);
            if (r[RATE_W-1]) begin
                if (r[RATE_W-2:0] == '0) begin
                    magnitude = '1;
                end else begin
                    magnitude = neg[MAG_W-1:0];
                end
            end else begin
                magnitude = r[MAG_W-1:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/tkm_cell.sv */
// one slot of the sorted chain: holds an entry, compares it against the
// broadcast candidate and shifts from its left neighbor; uses tkm_pkg
`timescale 1ns / 1ps
`default_nettype none

module tkm_cell (
    input  wire                          aclk,
    input  wire  [tkm_pkg::IDX_W-1:0]    idx,
    input  tkm_pkg::cmd_t                cmd,
    input  wire                          left_ge,
    input  tkm_pkg::slot_t               left_slot,
    output logic                         ge,
    output tkm_pkg::slot_t               slot,
    output logic                         bot_gt,
    output logic                         hit,
    output tkm_pkg::slot_t               pick,
    output logic [tkm_pkg::MAG_W-1:0]    bot_mag,
    output logic [tkm_pkg::MAG_W-1:0]    own_mag
);
    import tkm_pkg::*;

    slot_t            slot_reg;
    logic             live;
    logic             is_bottom;

    always_ff @(posedge aclk) begin
        if (cmd.upd) begin
            if (left_ge) begin
                slot_reg <= left_slot;
            end else if (ge) begin
                slot_reg <= cmd.slot;
            end
        end
    end

    always_comb begin
        own_mag   = magnitude(slot_reg.rate);
        live      = CNT_W'(idx) < cmd.held;
        is_bottom = (CNT_W'(idx) + CNT_W'(1)) == cmd.held;
        // empty slots count as below any candidate, so ge is monotonic
        ge        = !live || (cmd.mag >= own_mag);
        bot_gt    = is_bottom && (cmd.mag > own_mag);
        hit       = live && (CMP_W'(idx) == CMP_W'(cmd.rank));
        pick      = hit ? slot_reg : '0;
        bot_mag   = is_bottom ? own_mag : '0;
        slot      = slot_reg;
    end

endmodule

`default_nettype wire

/* hw/rtl/tkm_chain.sv */
// row of tkm_cell slots with or-reduction of the per-cell status
// uses tkm_pkg and tkm_cell
`timescale 1ns / 1ps
`default_nettype none

module tkm_chain (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  tkm_pkg::cmd_t         cmd,
    output tkm_pkg::chain_stat_t  stat
);
    import tkm_pkg::*;

    logic             ge_vec   [CAPACITY];
    slot_t            slot_vec [CAPACITY];
    logic             bgt_vec  [CAPACITY];
    logic             hit_vec  [CAPACITY];
    slot_t            pick_vec [CAPACITY];
    logic [MAG_W-1:0] bmag_vec [CAPACITY];
    logic [MAG_W-1:0] mag_vec  [CAPACITY];
    logic [CAPACITY-1:0] load_new;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic  lge;
            slot_t lslot;
            if (g == 0) begin : g_head
                assign lge   = 1'b0;
                assign lslot = cmd.slot;
            end else begin : g_body
                assign lge   = ge_vec[g-1];
                assign lslot = slot_vec[g-1];
            end

            tkm_cell u_cell (
                .aclk      (aclk),
                .idx       (IDX_W'(g)),
                .cmd       (cmd),
                .left_ge   (lge),
                .left_slot (lslot),
                .ge        (ge_vec[g]),
                .slot      (slot_vec[g]),
                .bot_gt    (bgt_vec[g]),
                .hit       (hit_vec[g]),
                .pick      (pick_vec[g]),
                .bot_mag   (bmag_vec[g]),
                .own_mag   (mag_vec[g])
            );

            assign load_new[g] = ge_vec[g] && !lge;
        end
    endgenerate

    // at most one cell matches each select, so an or gathers it
    always_comb begin
        stat         = '0;
        stat.top_mag = mag_vec[0];
        for (int i = 0; i < CAPACITY; i++) begin
            stat.bot_gt  = stat.bot_gt | bgt_vec[i];
            stat.hit     = stat.hit | hit_vec[i];
            stat.pick    = stat.pick | pick_vec[i];
            stat.bot_mag = stat.bot_mag | bmag_vec[i];
        end
    end

`ifndef NO_ASSERTIONS
    // the candidate lands in at most one cell
    a_one_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(load_new))
        else $error("candidate lands in more than one cell");

    // while the chain is not full, the last slot is empty and so sees the candidate at or above it
    a_tail_ge: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.held != CNT_W'(CAPACITY)) |-> ge_vec[CAPACITY-1])
        else $error("empty tail slot ranks above candidate");
`endif

endmodule

`default_nettype wire

/* hw/rtl/top_k_by_magnitude_tracker.sv */
// top level of the top-k magnitude tracker: stream ports, apb register,
// request control and the sorted cell chain; uses tkm_pkg and tkm_chain
`timescale 1ns / 1ps
`default_nettype none

// Keeps the keep_count entries of largest |rate| sorted in descending order in a
// chain of CAPACITY cells. Each request is first accepted; then every cell
// compares the candidate magnitude at once and, for an offer that is taken,
// the chain shifts to open the insertion slot; then the rank and bottom
// selects are or-gathered into the output register. The next request
// is accepted while that result waits on m_tready; a new result waits only
// when the previous one has not been taken. No clearing pass follows reset:
// slots beyond the entry count are never reported.
module top_k_by_magnitude_tracker (
    input  wire                            aclk,
    input  wire                            aresetn,
    // stream in
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // rate[31:0], tag[63:32], year[75:64], rank[82:76], zero pad
    input  wire  [tkm_pkg::S_DATA_W-1:0]   s_tdata,
    // opcode[0]
    input  wire  [tkm_pkg::S_USER_W-1:0]   s_tuser,
    // stream out
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // accepted[0], evicted[1], entry_count[9:2], max_magnitude[40:10],
    // min_magnitude[71:41], entry_valid[72], entry_rate[104:73],
    // entry_tag[136:105], entry_year[148:137], zero pad
    output logic [tkm_pkg::M_DATA_W-1:0]   m_tdata,
    // apb
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [tkm_pkg::ADDR_W-1:0]     paddr,
    input  wire  [tkm_pkg::PDATA_W-1:0]    pwdata,
    output logic [tkm_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import tkm_pkg::*;

    state_t            state_reg, state_next;
    op_t               op_reg;
    slot_t             req_slot_reg;
    logic [RANK_W-1:0] req_rank_reg;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [KEEP_W-1:0] keep_reg;
    logic              acc_reg, evi_reg;
    logic              m_tvalid_reg;

    logic              o_acc_reg, o_evi_reg, o_valid_reg;
    logic [CNTO_W-1:0] o_count_reg;
    logic [MAG_W-1:0]  o_max_reg, o_min_reg;
    slot_t             o_entry_reg;

    logic              req_load, out_load, upd, take, full;
    logic [CNT_W-1:0]  lim;
    cmd_t              cmd;
    chain_stat_t       stat;
    logic              apb_wr;

    // configuration
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_reg <= KEEP_RESET;
        end else if (apb_wr && (paddr[2] == REG_KEEP_COUNT)) begin
            keep_reg <= pwdata[KEEP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_KEEP_COUNT) ? PDATA_W'(keep_reg) : '0;

    // effective list length, zero means one, capped at CAPACITY
    always_comb begin
        if (keep_reg == '0) begin
            lim = CNT_W'(1);
        end else if (LIM_W'(keep_reg) > LIM_W'(CAPACITY)) begin
            lim = CNT_W'(CAPACITY);
        end else begin
            lim = CNT_W'(keep_reg);
        end
    end

    assign full = held_reg >= lim;
    assign take = (op_reg == OP_OFFER) && (!full || stat.bot_gt);

    always_comb begin
        cmd      = '0;
        cmd.upd  = upd;
        cmd.mag  = magnitude(req_slot_reg.rate);
        cmd.slot = req_slot_reg;
        cmd.rank = req_rank_reg;
        cmd.held = held_reg;
    end

    tkm_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = ST_GATHER;
            end
            ST_GATHER: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        s_tready = 1'b0;
        req_load = 1'b0;
        upd      = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                req_load = s_tvalid;
            end
            ST_UPDATE: begin
                upd = take;
            end
            ST_GATHER: begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign held_next = (upd && !full) ? held_reg + CNT_W'(1) : held_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            held_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            held_reg  <= held_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        if (req_load) begin
            op_reg            <= op_t'(s_tuser[0]);
            req_slot_reg.rate <= s_tdata[31:0];
            req_slot_reg.tag  <= s_tdata[63:32];
            req_slot_reg.year <= s_tdata[75:64];
            req_rank_reg      <= s_tdata[82:76];
        end
        if (state_reg == ST_UPDATE) begin
            acc_reg <= take;
            evi_reg <= take && full;
        end
        if (out_load) begin
            o_acc_reg   <= acc_reg;
            o_evi_reg   <= evi_reg;
            o_count_reg <= CNTO_W'(held_reg);
            o_max_reg   <= (held_reg != '0) ? stat.top_mag : '0;
            o_min_reg   <= stat.bot_mag;
            o_valid_reg <= (op_reg == OP_READ) && stat.hit;
            o_entry_reg <= (op_reg == OP_READ) ? stat.pick : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, o_entry_reg.year, o_entry_reg.tag, o_entry_reg.rate,
                       o_valid_reg, o_min_reg, o_max_reg, o_count_reg,
                       o_evi_reg, o_acc_reg};

`ifndef NO_ASSERTIONS
    a_held_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_UPDATE))
        else $error("accepted request did not reach the update cycle");

    a_held_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_UPDATE) |=> $stable(held_reg))
        else $error("entry count moved outside the update cycle");

    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd && !full) |=> (held_reg == $past(held_reg) + CNT_W'(1)))
        else $error("insert below the limit did not grow the list");
`endif

endmodule

`default_nettype wire
